// ===== design/gbt_pkg.sv =====
// Shared types and constants of the gap buffer text engine.
// Holds request codes, the controller command and status structs and field widths.
// Depends on nothing; every other design file but gbt_ram refers to it by scoped names.
package gbt_pkg;

    // Field widths of the request and response channels.
    localparam int TYPE_W = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 12;
    localparam int LEN_W  = 13;

    // Default store size in bytes.
    localparam int DEPTH_DEFAULT = 4096;

    // End sentinel byte that cell zero reads as after reset.
    localparam logic [CHAR_W-1:0] END_MARK = 8'hFE;

    // Request type codes.
    localparam logic [TYPE_W-1:0] REQ_LEFT   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_RIGHT  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_MOVE   = 3'd5;

    // Datapath micro-operation selected by the controller.
    typedef enum logic [2:0] {
        STEP_LEFT,
        STEP_RIGHT,
        STEP_INS_LO,
        STEP_INS_HI,
        STEP_INS0,
        STEP_DEL,
        STEP_FETCH
    } step_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_req;
        logic  rd_en;
        logic  exec;
        logic  set_refused;
        logic  load_rsp;
        step_t step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              can_left;
        logic              can_right;
        logic              full;
        logic              lc_zero;
        logic              lc_gt1;
        logic              read_ok;
        logic              move_dn;
        logic              move_up;
        logic              out_free;
    } sts_t;

endpackage

// ===== design/gbt_req_if.sv =====
// Request channel of the gap buffer text engine: valid, ready and the request fields.
// Depends on gbt_pkg for the field widths.
interface gbt_req_if;
    logic                        valid;
    logic                        ready;
    logic [gbt_pkg::TYPE_W-1:0]  req_type;
    logic [gbt_pkg::CHAR_W-1:0]  char_in;
    logic [gbt_pkg::POS_W-1:0]   position;

    modport source (output valid, output req_type, output char_in, output position,
                    input ready);
    modport sink   (input valid, input req_type, input char_in, input position,
                    output ready);
endinterface

// ===== design/gbt_rsp_if.sv =====
// Response channel of the gap buffer text engine: valid, ready and the result fields.
// Depends on gbt_pkg for the field widths.
interface gbt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [gbt_pkg::CHAR_W-1:0]  read_char;
    logic [gbt_pkg::LEN_W-1:0]   text_length;
    logic [gbt_pkg::LEN_W-1:0]   cursor_pos;
    logic                        status;

    modport source (output valid, output read_char, output text_length, output cursor_pos,
                    output status, input ready);
    modport sink   (input valid, input read_char, input text_length, input cursor_pos,
                    input status, output ready);
endinterface

// ===== design/gap_buffer_text_engine_unit.sv =====
// Gap buffer text engine: requests move the cursor, insert, delete, read or walk.
// Request channel req carries req_type, char_in and position; response channel rsp
// carries read_char, text_length, cursor_pos and status, one response per request.
// Both channels move a request or result at a clock edge with valid and ready high.
// Requests are handled one at a time. From acceptance to the loading of the result, a
// step, a delete or a read passes decode, RAM read, RAM write and respond; an insert
// adds a second RAM write; an insert with an empty left span passes decode, RAM write,
// chain, a RAM read and write if a right byte is pulled over, and respond; a refused or
// no-op request passes decode and respond; a move passes decode, RAM read and RAM write
// per byte walked, then decode and respond; idle precedes the next request. The byte RAM,
// which must be read and then written for every byte moved, sets these figures.
// The result sits in an output register, so the next request is accepted while it
// waits; if the receiver stalls, the following result holds in the respond state
// and no further request is taken until the register frees up.
// Reset (rst_n low, asynchronous) empties the text to the lone end sentinel 0xFE:
// text_length 1, cursor_pos 1. No clearing pass is needed after reset.
// Depends on gbt_pkg, gbt_req_if, gbt_rsp_if, gbt_ctrl, gbt_datapath and gbt_ram.
module gap_buffer_text_engine_unit #(
    parameter int DEPTH = gbt_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    gbt_req_if.sink    req,
    gbt_rsp_if.source  rsp
);

    gbt_pkg::cmd_t cmd;
    gbt_pkg::sts_t sts;

    // Sequencer for each request.
    gbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Counters, byte store and response register.
    gbt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req.req_type),
        .char_in     (req.char_in),
        .position    (req.position),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .read_char   (rsp.read_char),
        .text_length (rsp.text_length),
        .cursor_pos  (rsp.cursor_pos),
        .status      (rsp.status)
    );

endmodule

// ===== design/gbt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/gbt_ctrl.sv =====
// Controller state machine of the gap buffer text engine.
// Sequences decode, memory read, memory write and response per request.
// Depends on gbt_pkg for the command and status structs and request codes.
module gbt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  gbt_pkg::sts_t sts,
    output gbt_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_READ   = 6'b000100,
        S_WRITE  = 6'b001000,
        S_CHAIN  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    gbt_pkg::step_t step_reg;
    gbt_pkg::step_t step_next;
    logic           is_move;

    assign is_move = (sts.req_type == gbt_pkg::REQ_MOVE);

    // Next state, next micro-operation and command decode.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                unique case (sts.req_type)
                    gbt_pkg::REQ_LEFT:
                    begin
                        if (sts.can_left)
                        begin
                            step_next  = gbt_pkg::STEP_LEFT;
                            state_next = S_READ;
                        end
                    end
                    gbt_pkg::REQ_RIGHT:
                    begin
                        if (sts.can_right)
                        begin
                            step_next  = gbt_pkg::STEP_RIGHT;
                            state_next = S_READ;
                        end
                    end
                    gbt_pkg::REQ_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_refused = 1'b1;
                        end
                        else if (sts.lc_zero)
                        begin
                            step_next  = gbt_pkg::STEP_INS0;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            step_next  = gbt_pkg::STEP_INS_LO;
                            state_next = S_READ;
                        end
                    end
                    gbt_pkg::REQ_DELETE:
                    begin
                        if (sts.lc_gt1)
                        begin
                            step_next  = gbt_pkg::STEP_DEL;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.set_refused = 1'b1;
                        end
                    end
                    gbt_pkg::REQ_READ:
                    begin
                        if (sts.read_ok)
                        begin
                            step_next  = gbt_pkg::STEP_FETCH;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.set_refused = 1'b1;
                        end
                    end
                    gbt_pkg::REQ_MOVE:
                    begin
                        // Walk one byte per pass until the target or an end is reached.
                        if (sts.move_dn && sts.can_left)
                        begin
                            step_next  = gbt_pkg::STEP_LEFT;
                            state_next = S_READ;
                        end
                        else if (sts.move_up && sts.can_right)
                        begin
                            step_next  = gbt_pkg::STEP_RIGHT;
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        cmd.set_refused = 1'b1;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.exec = 1'b1;
                case (step_reg) inside
                    gbt_pkg::STEP_INS_LO:
                    begin
                        // The displaced cursor byte is written on the next cycle.
                        step_next = gbt_pkg::STEP_INS_HI;
                    end
                    gbt_pkg::STEP_INS0:
                    begin
                        state_next = S_CHAIN;
                    end
                    gbt_pkg::STEP_LEFT, gbt_pkg::STEP_RIGHT:
                    begin
                        state_next = is_move ? S_DECODE : S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_CHAIN:
            begin
                // An insert into an empty left span pulls the first right byte over.
                if (sts.can_right)
                begin
                    step_next  = gbt_pkg::STEP_RIGHT;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= gbt_pkg::STEP_FETCH;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== design/gbt_datapath.sv =====
// Datapath of the gap buffer text engine: span counters, byte store, response register.
// Depends on gbt_pkg and instantiates gbt_ram.
module gbt_datapath #(
    parameter int DEPTH = gbt_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gbt_pkg::cmd_t               cmd,
    output gbt_pkg::sts_t               sts,
    input  logic [gbt_pkg::TYPE_W-1:0]  req_type,
    input  logic [gbt_pkg::CHAR_W-1:0]  char_in,
    input  logic [gbt_pkg::POS_W-1:0]   position,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [gbt_pkg::CHAR_W-1:0]  read_char,
    output logic [gbt_pkg::LEN_W-1:0]   text_length,
    output logic [gbt_pkg::LEN_W-1:0]   cursor_pos,
    output logic                        status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > gbt_pkg::LEN_W) ? CW : gbt_pkg::LEN_W;

    // Span counters.
    logic [CW-1:0] lc_reg;
    logic [CW-1:0] lc_next;
    logic [CW-1:0] rs_reg;
    logic [CW-1:0] rs_next;

    // Latched request.
    logic [gbt_pkg::TYPE_W-1:0] type_reg;
    logic [gbt_pkg::CHAR_W-1:0] char_reg;
    logic [gbt_pkg::POS_W-1:0]  pos_reg;

    // Per-request results.
    logic [gbt_pkg::CHAR_W-1:0] rd_char_reg;
    logic                       refused_reg;

    // Sentinel tracking for cell zero.
    logic cell0_valid_reg;
    logic sent_reg;

    // Response register.
    logic                       rsp_valid_reg;
    logic [gbt_pkg::CHAR_W-1:0] out_char_reg;
    logic [gbt_pkg::LEN_W-1:0]  out_len_reg;
    logic [gbt_pkg::LEN_W-1:0]  out_cur_reg;
    logic                       out_st_reg;

    // Memory port signals.
    logic                       ram_wr_en;
    logic [AW-1:0]              ram_wr_addr;
    logic [gbt_pkg::CHAR_W-1:0] ram_wr_data;
    logic [AW-1:0]              ram_rd_addr;
    logic [gbt_pkg::CHAR_W-1:0] ram_rd_data;
    logic [gbt_pkg::CHAR_W-1:0] rdata_eff;

    // Wide views for compares against the position field.
    logic [XW-1:0] lc_x;
    logic [XW-1:0] rs_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] size_x;
    logic [XW-1:0] target_x;
    logic [XW-1:0] rd_addr_x;
    logic [CW-1:0] wr_addr_c;

    assign lc_x     = XW'(lc_reg);
    assign rs_x     = XW'(rs_reg);
    assign pos_x    = XW'(pos_reg);
    assign size_x   = lc_x + XW'(DEPTH) - rs_x;
    assign target_x = pos_x + XW'(1);

    // Status toward the controller.
    always_comb
    begin
        sts.req_type  = type_reg;
        sts.can_left  = (lc_reg != '0) && (rs_reg > lc_reg);
        sts.can_right = (rs_reg != CW'(DEPTH)) && (lc_reg < rs_reg);
        sts.full      = (lc_reg >= rs_reg);
        sts.lc_zero   = (lc_reg == '0);
        sts.lc_gt1    = (lc_reg > CW'(1));
        sts.read_ok   = (pos_x < size_x);
        sts.move_dn   = (lc_x > target_x);
        sts.move_up   = (lc_x < target_x);
        sts.out_free  = !rsp_valid_reg || rsp_ready;
    end

    // Read address: a logical index for reads, otherwise next to the cursor or gap.
    always_comb
    begin
        case (cmd.step)
            gbt_pkg::STEP_FETCH:
            begin
                if (pos_x < lc_x)
                begin
                    rd_addr_x = pos_x;
                end
                else
                begin
                    rd_addr_x = rs_x + pos_x - lc_x;
                end
            end
            gbt_pkg::STEP_RIGHT:
            begin
                rd_addr_x = rs_x;
            end
            default:
            begin
                rd_addr_x = lc_x - XW'(1);
            end
        endcase
    end

    assign ram_rd_addr = rd_addr_x[AW-1:0];

    // Cell zero reads as the sentinel until it is first written.
    assign rdata_eff = sent_reg ? gbt_pkg::END_MARK : ram_rd_data;

    // Write port and counter updates for the executing micro-operation.
    always_comb
    begin
        wr_addr_c   = lc_reg;
        ram_wr_data = rdata_eff;
        ram_wr_en   = cmd.exec;
        lc_next     = lc_reg;
        rs_next     = rs_reg;
        case (cmd.step)
            gbt_pkg::STEP_LEFT:
            begin
                wr_addr_c = rs_reg - CW'(1);
                lc_next   = lc_reg - CW'(1);
                rs_next   = rs_reg - CW'(1);
            end
            gbt_pkg::STEP_RIGHT:
            begin
                lc_next = lc_reg + CW'(1);
                rs_next = rs_reg + CW'(1);
            end
            gbt_pkg::STEP_INS_LO:
            begin
                wr_addr_c   = lc_reg - CW'(1);
                ram_wr_data = char_reg;
            end
            gbt_pkg::STEP_INS_HI:
            begin
                lc_next = lc_reg + CW'(1);
            end
            gbt_pkg::STEP_INS0:
            begin
                wr_addr_c   = '0;
                ram_wr_data = char_reg;
                lc_next     = CW'(1);
            end
            gbt_pkg::STEP_DEL:
            begin
                wr_addr_c = lc_reg - CW'(2);
                lc_next   = lc_reg - CW'(1);
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    assign ram_wr_addr = wr_addr_c[AW-1:0];

    gbt_ram #(
        .WIDTH (gbt_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Control registers: counters, sentinel flag and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg          <= CW'(1);
            rs_reg          <= CW'(DEPTH);
            cell0_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                lc_reg <= lc_next;
                rs_reg <= rs_next;
            end
            if (ram_wr_en && (ram_wr_addr == '0))
            begin
                cell0_valid_reg <= 1'b1;
            end
            if (cmd.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latched request, per-request results, response fields.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg    <= req_type;
            char_reg    <= char_in;
            pos_reg     <= position;
            rd_char_reg <= '0;
            refused_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_refused)
            begin
                refused_reg <= 1'b1;
            end
            if (cmd.exec && (cmd.step == gbt_pkg::STEP_FETCH))
            begin
                rd_char_reg <= rdata_eff;
            end
        end
        if (cmd.rd_en)
        begin
            sent_reg <= (ram_rd_addr == '0) && !cell0_valid_reg;
        end
        if (cmd.load_rsp)
        begin
            out_char_reg <= rd_char_reg;
            out_len_reg  <= size_x[gbt_pkg::LEN_W-1:0];
            out_cur_reg  <= lc_x[gbt_pkg::LEN_W-1:0];
            out_st_reg   <= refused_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_char   = out_char_reg;
    assign text_length = out_len_reg;
    assign cursor_pos  = out_cur_reg;
    assign status      = out_st_reg;

    // The left span never runs into the right span.
    a_spans_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= rs_reg)
        else $error("left span overlaps right span");

    // The right span never starts beyond the end of the store.
    a_rs_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rs_reg <= CW'(DEPTH))
        else $error("right span start beyond store");

    // A left step only runs with a non-empty left span and a non-empty gap.
    a_left_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (cmd.step == gbt_pkg::STEP_LEFT)) |->
        ((lc_reg != '0) && (rs_reg > lc_reg)))
        else $error("left step without room");

    // A response is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rsp |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwritten");

endmodule
